// ===== rtl/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsa_pkg - shared types and constants
// Widths, command and status codes, and the segment compare result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsa_pkg;

  // address and size width
  localparam int AW = 32;

  // stream payload widths (bits, zero filled)
  localparam int IN_W  = 72;
  localparam int OUT_W = 136;
  localparam int CFG_W = 5;

  // commands
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_RESIZE = 2'd2;

  // status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_SHORT_MEM  = 4'd1;
  localparam logic [3:0] ST_DUP_HANDLE = 4'd2;
  localparam logic [3:0] ST_NO_CONTIG  = 4'd3;
  localparam logic [3:0] ST_UNKNOWN    = 4'd4;
  localparam logic [3:0] ST_BELOW_USED = 4'd5;
  localparam logic [3:0] ST_BELOW_HW   = 4'd6;
  localparam logic [3:0] ST_INCONSIST  = 4'd7;
  localparam logic [3:0] ST_FULL       = 4'd8;

  // per-entry compare result of the segment scan
  typedef struct packed {
    logic end_hit;    // valid entry ending at the end key
    logic start_hit;  // valid entry starting at the start key
    logic better;     // fits and beats the current best
  } seg_cmp_t;

endpackage

`default_nettype wire

// ===== rtl/bfsa_ram.sv =====
// ----------------------------------------------------------------------------
// bfsa_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bfsa_seg_cmp.sv =====
// ----------------------------------------------------------------------------
// bfsa_seg_cmp - segment entry compare unit
// Used by the segment scan: end and start matches, fit and best-fit ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_seg_cmp (
  input  wire logic                   valid,
  input  wire logic [bfsa_pkg::AW-1:0] seg_start,
  input  wire logic [bfsa_pkg::AW-1:0] seg_size,
  input  wire logic [bfsa_pkg::AW-1:0] key_end,
  input  wire logic [bfsa_pkg::AW-1:0] key_start,
  input  wire logic [bfsa_pkg::AW-1:0] need,
  input  wire logic                   best_ok,
  input  wire logic [bfsa_pkg::AW-1:0] best_start,
  input  wire logic [bfsa_pkg::AW-1:0] best_size,
  output bfsa_pkg::seg_cmp_t          res
);

  logic [bfsa_pkg::AW-1:0] seg_end;
  logic                    fits;

  assign seg_end = seg_start + seg_size;
  assign fits    = valid && (seg_size >= need);

  // smallest fitting size, lowest start on ties
  assign res.end_hit   = valid && (seg_end == key_end);
  assign res.start_hit = valid && (seg_start == key_start);
  assign res.better    = fits && (!best_ok || (seg_size < best_size) ||
                         ((seg_size == best_size) && (seg_start < best_start)));

endmodule

`default_nettype wire

// ===== rtl/best_fit_segment_allocator_core.sv =====
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_core - aligned best-fit allocator
// Alloc, free and resize over a segment table and a handle table.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes align_log2; always ready,
//   write it only while the block is idle.
//   s_t* takes one request: tdata = command[1:0], handle[33:2],
//   request_size[65:34]. s_tready is high only while the sequencer is idle.
//   m_t* returns one result per request: tdata = status[3:0], offset[35:4],
//   granted_size[67:36], free_total[99:68], high_water_mark[131:100].
// Sequence: every request runs a prepare step, a handle table scan (alloc,
//   free), a segment table scan (alloc, free, resize) and a commit step;
//   early rejects skip the scans that remain. The next request is taken
//   only once the sequencer is back in idle after the commit. Each scan
//   reads one table entry per cycle from its RAM port; the segment scan
//   passes each entry through the compare unit.
// Reset clears all table valid bits, sizes, high-water mark and align_log2;
//   no clearing pass. A stalled result is held in the output register; the
//   next request is accepted and scanned, and commits once the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_segment_allocator_core #(
  parameter int MAX_HANDLES  = 64,
  parameter int MAX_SEGMENTS = 65
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration: align_log2
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bfsa_pkg::CFG_W-1:0]    cfg_data,
  // requests: command, handle, request_size (low bits first)
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [bfsa_pkg::IN_W-1:0]     s_tdata,
  // results: status, offset, granted_size, free_total, high_water_mark
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [bfsa_pkg::OUT_W-1:0]    m_tdata
);

  localparam int AW   = bfsa_pkg::AW;
  localparam int HIW  = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
  localparam int SIW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int MAXN = (MAX_HANDLES > MAX_SEGMENTS) ? MAX_HANDLES : MAX_SEGMENTS;
  localparam int CW   = $clog2(MAXN + 1);
  localparam logic [CW-1:0] HLIM = CW'(MAX_HANDLES);
  localparam logic [CW-1:0] SLIM = CW'(MAX_SEGMENTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ASCAN,
    S_SSCAN,
    S_DECIDE
  } state_t;

  state_t state;

  // request and architectural state
  logic [1:0]    cmd_q;
  logic [AW-1:0] handle_q, req_q;
  logic [AW:0]   size_q;
  logic [AW-1:0] nsz_q;
  logic [4:0]    align_q;
  logic [AW-1:0] mem_size_q, mem_free_q, hw_q;
  logic [MAX_SEGMENTS-1:0] seg_valid_q;
  logic [MAX_HANDLES-1:0]  alloc_valid_q;

  // scan control
  logic [CW-1:0] cnt_q, didx_q;
  logic          dok_q;

  // scan results
  logic           dup_q, slot_ok_q, a_ok_q;
  logic [HIW-1:0] slot_q, a_idx_q;
  logic [AW-1:0]  a_off_q, a_size_q;
  logic           best_ok_q, l_ok_q, r_ok_q, e_ok_q;
  logic [SIW-1:0] best_idx_q, l_idx_q, r_idx_q, e_idx_q;
  logic [AW-1:0]  best_start_q, best_size_q, l_start_q, l_size_q, r_size_q;
  logic [AW-1:0]  key_end_q, key_start_q;
  logic           early_q;
  logic [3:0]     early_st_q;

  // output register
  logic [3:0]    o_st;
  logic [AW-1:0] o_off, o_gsz, o_free, o_hw;

  // RAM ports
  logic                 seg_we, alloc_we;
  logic [SIW-1:0]       seg_wa;
  logic [HIW-1:0]       alloc_wa;
  logic [2*AW-1:0]      seg_wd, seg_rd;
  logic [3*AW-1:0]      alloc_wd, alloc_rd;

  // request fields
  logic [1:0]    in_cmd;
  logic [AW-1:0] in_handle, in_req;
  assign in_cmd    = s_tdata[1:0];
  assign in_handle = s_tdata[33:2];
  assign in_req    = s_tdata[65:34];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tdata   = {4'd0, o_hw, o_free, o_gsz, o_off, o_st};

  logic can_emit, emit;
  assign can_emit = !m_tvalid || m_tready;
  assign emit     = (state == S_DECIDE) && can_emit;

  // table memories
  bfsa_ram #(.WIDTH(2 * AW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_wa),
    .wdata (seg_wd),
    .raddr (cnt_q[SIW-1:0]),
    .rdata (seg_rd)
  );

  bfsa_ram #(.WIDTH(3 * AW), .DEPTH(MAX_HANDLES)) u_alloc_ram (
    .clk   (clk),
    .we    (alloc_we),
    .waddr (alloc_wa),
    .wdata (alloc_wd),
    .raddr (cnt_q[HIW-1:0]),
    .rdata (alloc_rd)
  );

  // entry under inspection
  logic [AW-1:0] rs_start, rs_size, ra_handle, ra_off, ra_size;
  logic          rs_v, ra_v;
  assign rs_start  = seg_rd[2*AW-1:AW];
  assign rs_size   = seg_rd[AW-1:0];
  assign ra_handle = alloc_rd[3*AW-1:2*AW];
  assign ra_off    = alloc_rd[2*AW-1:AW];
  assign ra_size   = alloc_rd[AW-1:0];
  assign rs_v      = seg_valid_q[didx_q[SIW-1:0]];
  assign ra_v      = alloc_valid_q[didx_q[HIW-1:0]];

  bfsa_pkg::seg_cmp_t cmp;

  bfsa_seg_cmp u_cmp (
    .valid      (rs_v),
    .seg_start  (rs_start),
    .seg_size   (rs_size),
    .key_end    (key_end_q),
    .key_start  (key_start_q),
    .need       (size_q[AW-1:0]),
    .best_ok    (best_ok_q),
    .best_start (best_start_q),
    .best_size  (best_size_q),
    .res        (cmp)
  );

  // scan stepping
  logic          issue, scan_done;
  logic [CW-1:0] lim;
  assign lim       = (state == S_ASCAN) ? HLIM : SLIM;
  assign issue     = cnt_q < lim;
  assign scan_done = !issue && !dok_q;

  // prepare-cycle arithmetic
  logic [AW:0]   amask, asize;
  logic [AW-1:0] p_nsz, p_used;
  assign amask  = (33'd1 << align_q) - 33'd1;
  assign asize  = ({1'b0, req_q} + amask) & ~amask;
  assign p_nsz  = req_q & ~amask[AW-1:0];
  assign p_used = mem_size_q - mem_free_q;

  // commit decision
  logic [3:0]     d_st;
  logic [AW-1:0]  d_off, d_gsz, d_free, d_hw, d_msize;
  logic           seg_set, seg_clr, alloc_set, alloc_clr;
  logic [SIW-1:0] seg_set_idx, seg_clr_idx;
  logic [AW-1:0]  d_end, f_end, delta;
  logic           grow;

  always_comb begin
    d_st        = early_st_q;
    d_off       = '0;
    d_gsz       = '0;
    d_free      = mem_free_q;
    d_hw        = hw_q;
    d_msize     = mem_size_q;
    seg_we      = 1'b0;
    seg_wa      = '0;
    seg_wd      = '0;
    seg_set     = 1'b0;
    seg_set_idx = '0;
    seg_clr     = 1'b0;
    seg_clr_idx = '0;
    alloc_we    = 1'b0;
    alloc_wa    = slot_q;
    alloc_wd    = {handle_q, best_start_q, size_q[AW-1:0]};
    alloc_set   = 1'b0;
    alloc_clr   = 1'b0;
    d_end       = best_start_q + size_q[AW-1:0];
    f_end       = a_off_q + a_size_q;
    grow        = nsz_q > mem_size_q;
    delta       = grow ? (nsz_q - mem_size_q) : (mem_size_q - nsz_q);
    if (!early_q) begin
      case (cmd_q)
        bfsa_pkg::CMD_ALLOC: begin
          if (!best_ok_q) begin
            d_st = bfsa_pkg::ST_NO_CONTIG;
          end else if (!slot_ok_q) begin
            d_st = bfsa_pkg::ST_FULL;
          end else begin
            d_st      = bfsa_pkg::ST_OK;
            d_off     = best_start_q;
            d_gsz     = size_q[AW-1:0];
            d_free    = mem_free_q - size_q[AW-1:0];
            d_hw      = (hw_q < d_end) ? d_end : hw_q;
            seg_we    = 1'b1;
            seg_wa    = best_idx_q;
            seg_wd    = {d_end, best_size_q - size_q[AW-1:0]};
            seg_clr   = (best_size_q == size_q[AW-1:0]);
            seg_clr_idx = best_idx_q;
            alloc_we  = 1'b1;
            alloc_set = 1'b1;
          end
        end
        bfsa_pkg::CMD_FREE: begin
          if (l_ok_q && (a_off_q < l_size_q)) begin
            d_st = bfsa_pkg::ST_INCONSIST;
          end else if (!l_ok_q && !r_ok_q && !e_ok_q) begin
            d_st = bfsa_pkg::ST_FULL;
          end else begin
            d_st      = bfsa_pkg::ST_OK;
            d_gsz     = a_size_q;
            d_free    = mem_free_q + a_size_q;
            alloc_clr = 1'b1;
            if (f_end == hw_q) begin
              d_hw = a_off_q - (l_ok_q ? l_size_q : '0);
            end
            if (l_ok_q && r_ok_q && (l_idx_q != r_idx_q)) begin
              // bridge: left absorbs block and right neighbor
              seg_we      = 1'b1;
              seg_wa      = l_idx_q;
              seg_wd      = {l_start_q, l_size_q + a_size_q + r_size_q};
              seg_clr     = 1'b1;
              seg_clr_idx = r_idx_q;
            end else if (l_ok_q) begin
              seg_we = 1'b1;
              seg_wa = l_idx_q;
              seg_wd = {l_start_q, l_size_q + a_size_q};
            end else if (r_ok_q) begin
              seg_we = 1'b1;
              seg_wa = r_idx_q;
              seg_wd = {a_off_q, r_size_q + a_size_q};
            end else if (a_size_q != '0) begin
              seg_we      = 1'b1;
              seg_wa      = e_idx_q;
              seg_wd      = {a_off_q, a_size_q};
              seg_set     = 1'b1;
              seg_set_idx = e_idx_q;
            end
          end
        end
        bfsa_pkg::CMD_RESIZE: begin
          d_st = bfsa_pkg::ST_OK;
          if (l_ok_q) begin
            if (grow) begin
              seg_we = 1'b1;
              seg_wa = l_idx_q;
              seg_wd = {l_start_q, l_size_q + delta};
            end else if (delta > l_size_q) begin
              d_st = bfsa_pkg::ST_INCONSIST;
            end else begin
              seg_we      = 1'b1;
              seg_wa      = l_idx_q;
              seg_wd      = {l_start_q, l_size_q - delta};
              seg_clr     = (delta == l_size_q);
              seg_clr_idx = l_idx_q;
            end
          end else if (!grow) begin
            d_st = bfsa_pkg::ST_INCONSIST;
          end else if (!e_ok_q) begin
            d_st = bfsa_pkg::ST_FULL;
          end else begin
            seg_we      = 1'b1;
            seg_wa      = e_idx_q;
            seg_wd      = {mem_size_q, delta};
            seg_set     = 1'b1;
            seg_set_idx = e_idx_q;
          end
          if (d_st == bfsa_pkg::ST_OK) begin
            d_msize = nsz_q;
            d_free  = grow ? (mem_free_q + delta) : (mem_free_q - delta);
          end
        end
        default: begin
          d_st = bfsa_pkg::ST_INCONSIST;
        end
      endcase
    end
    // nothing commits until the result register is free
    if (!emit) begin
      seg_we   = 1'b0;
      alloc_we = 1'b0;
    end
  end

  // sequencer, scan registers, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      align_q       <= '0;
      mem_size_q    <= '0;
      mem_free_q    <= '0;
      hw_q          <= '0;
      seg_valid_q   <= '0;
      alloc_valid_q <= '0;
      m_tvalid      <= 1'b0;
      dok_q         <= 1'b0;
      cnt_q         <= '0;
    end else begin
      if (cfg_valid) begin
        align_q <= cfg_data;
      end
      // result valid: set on commit, cleared when taken
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q    <= in_cmd;
            handle_q <= in_handle;
            req_q    <= in_req;
            state    <= S_PREP;
          end
        end
        S_PREP: begin
          early_q    <= 1'b0;
          early_st_q <= bfsa_pkg::ST_OK;
          cnt_q      <= '0;
          dok_q      <= 1'b0;
          dup_q      <= 1'b0;
          slot_ok_q  <= 1'b0;
          a_ok_q     <= 1'b0;
          best_ok_q  <= 1'b0;
          l_ok_q     <= 1'b0;
          r_ok_q     <= 1'b0;
          e_ok_q     <= 1'b0;
          size_q     <= asize;
          nsz_q      <= p_nsz;
          key_end_q  <= mem_size_q;
          case (cmd_q)
            bfsa_pkg::CMD_ALLOC: begin
              if ({1'b0, mem_free_q} < asize) begin
                early_q    <= 1'b1;
                early_st_q <= bfsa_pkg::ST_SHORT_MEM;
                state      <= S_DECIDE;
              end else begin
                state <= S_ASCAN;
              end
            end
            bfsa_pkg::CMD_FREE: begin
              state <= S_ASCAN;
            end
            bfsa_pkg::CMD_RESIZE: begin
              if (p_nsz < p_used) begin
                early_q    <= 1'b1;
                early_st_q <= bfsa_pkg::ST_BELOW_USED;
                state      <= S_DECIDE;
              end else if (p_nsz < hw_q) begin
                early_q    <= 1'b1;
                early_st_q <= bfsa_pkg::ST_BELOW_HW;
                state      <= S_DECIDE;
              end else if (p_nsz == mem_size_q) begin
                early_q <= 1'b1;
                state   <= S_DECIDE;
              end else begin
                state <= S_SSCAN;
              end
            end
            default: begin
              early_q    <= 1'b1;
              early_st_q <= bfsa_pkg::ST_INCONSIST;
              state      <= S_DECIDE;
            end
          endcase
        end
        S_ASCAN: begin
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          dok_q  <= issue;
          didx_q <= cnt_q;
          if (dok_q) begin
            if (ra_v && (ra_handle == handle_q)) begin
              dup_q <= 1'b1;
              if (!a_ok_q) begin
                a_ok_q   <= 1'b1;
                a_idx_q  <= didx_q[HIW-1:0];
                a_off_q  <= ra_off;
                a_size_q <= ra_size;
              end
            end
            if (!ra_v && !slot_ok_q) begin
              slot_ok_q <= 1'b1;
              slot_q    <= didx_q[HIW-1:0];
            end
          end
          if (scan_done) begin
            cnt_q <= '0;
            if (cmd_q == bfsa_pkg::CMD_ALLOC) begin
              if (dup_q) begin
                early_q    <= 1'b1;
                early_st_q <= bfsa_pkg::ST_DUP_HANDLE;
                state      <= S_DECIDE;
              end else begin
                state <= S_SSCAN;
              end
            end else if (!a_ok_q) begin
              early_q    <= 1'b1;
              early_st_q <= bfsa_pkg::ST_UNKNOWN;
              state      <= S_DECIDE;
            end else begin
              key_end_q   <= a_off_q;
              key_start_q <= a_off_q + a_size_q;
              state       <= S_SSCAN;
            end
          end
        end
        S_SSCAN: begin
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          dok_q  <= issue;
          didx_q <= cnt_q;
          if (dok_q) begin
            if (cmp.better) begin
              best_ok_q    <= 1'b1;
              best_idx_q   <= didx_q[SIW-1:0];
              best_start_q <= rs_start;
              best_size_q  <= rs_size;
            end
            if (cmp.end_hit && !l_ok_q) begin
              l_ok_q    <= 1'b1;
              l_idx_q   <= didx_q[SIW-1:0];
              l_start_q <= rs_start;
              l_size_q  <= rs_size;
            end
            if (cmp.start_hit && !r_ok_q) begin
              r_ok_q   <= 1'b1;
              r_idx_q  <= didx_q[SIW-1:0];
              r_size_q <= rs_size;
            end
            if (!rs_v && !e_ok_q) begin
              e_ok_q  <= 1'b1;
              e_idx_q <= didx_q[SIW-1:0];
            end
          end
          if (scan_done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (can_emit) begin
            o_st       <= d_st;
            o_off      <= d_off;
            o_gsz      <= d_gsz;
            o_free     <= d_free;
            o_hw       <= d_hw;
            mem_free_q <= d_free;
            hw_q       <= d_hw;
            mem_size_q <= d_msize;
            if (seg_clr) begin
              seg_valid_q[seg_clr_idx] <= 1'b0;
            end
            if (seg_set) begin
              seg_valid_q[seg_set_idx] <= 1'b1;
            end
            if (alloc_set) begin
              alloc_valid_q[slot_q] <= 1'b1;
            end
            if (alloc_clr) begin
              alloc_valid_q[a_idx_q] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfsa_checker.sv =====
// ----------------------------------------------------------------------------
// bfsa_checker - port-level checks for the allocator core
// Result channel behavior over time, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [bfsa_pkg::OUT_W-1:0] m_tdata
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] <= bfsa_pkg::ST_FULL))
    else $error("undefined status code");

  // a refused request reports no offset and no size
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:0] != bfsa_pkg::ST_OK) |->
      (m_tdata[35:4] == '0) && (m_tdata[67:36] == '0))
    else $error("refused request carries offset or size");

endmodule

bind best_fit_segment_allocator_core bfsa_checker u_bfsa_checker (.*);

`default_nettype wire
